// ===== sv/lcdt_pkg.sv =====
package lcdt_pkg;

    // Line timing
    localparam int LINE_CYCLES   = 456;
    localparam int SEARCH_CYCLES = 80;
    localparam int DRAW_CYCLES   = 172;
    localparam int VISIBLE_LINES = 144;
    localparam int BLANK_LINES   = 10;

    localparam int DOT_W  = 9;
    localparam int LINE_W = 8;
    localparam int BYTE_W = 8;

    // Dot thresholds within a line, line thresholds within a frame
    localparam logic [DOT_W-1:0]  SEARCH_END   = DOT_W'(SEARCH_CYCLES);
    localparam logic [DOT_W-1:0]  DRAW_END     = DOT_W'(SEARCH_CYCLES + DRAW_CYCLES);
    localparam logic [DOT_W-1:0]  LINE_END     = DOT_W'(LINE_CYCLES);
    localparam logic [LINE_W-1:0] VBLANK_START = LINE_W'(VISIBLE_LINES);
    localparam logic [LINE_W-1:0] FRAME_LINES  = LINE_W'(VISIBLE_LINES + BLANK_LINES);

    // Register map (low address byte)
    localparam logic [BYTE_W-1:0] ADDR_CONTROL  = 8'h40;
    localparam logic [BYTE_W-1:0] ADDR_STATUS   = 8'h41;
    localparam logic [BYTE_W-1:0] ADDR_SCROLL_Y = 8'h42;
    localparam logic [BYTE_W-1:0] ADDR_SCROLL_X = 8'h43;
    localparam logic [BYTE_W-1:0] ADDR_LINE     = 8'h44;
    localparam logic [BYTE_W-1:0] ADDR_COMPARE  = 8'h45;
    localparam logic [BYTE_W-1:0] ADDR_DMA      = 8'h46;
    localparam logic [BYTE_W-1:0] ADDR_BG_PAL   = 8'h47;
    localparam logic [BYTE_W-1:0] ADDR_OBJ_PAL0 = 8'h48;
    localparam logic [BYTE_W-1:0] ADDR_OBJ_PAL1 = 8'h49;
    localparam logic [BYTE_W-1:0] ADDR_WIN_Y    = 8'h4A;
    localparam logic [BYTE_W-1:0] ADDR_WIN_X    = 8'h4B;

    // Reset values and fixed bytes
    localparam logic [BYTE_W-1:0] CONTROL_RST     = 8'h91;
    localparam logic [BYTE_W-1:0] STATUS_RST      = 8'h85;
    localparam logic [BYTE_W-1:0] BG_PAL_RST      = 8'hFC;
    localparam logic [BYTE_W-1:0] OBJ_PAL_RST     = 8'hFF;
    localparam logic [BYTE_W-1:0] STATUS_KEEP     = 8'b1111_1100;
    localparam logic [BYTE_W-1:0] STATUS_FORCED   = 8'h80;
    localparam logic [BYTE_W-1:0] READ_IDLE_VALUE = 8'hFF;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_SEARCH = 2'd2,
        MODE_DRAW   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]        op;
        logic [BYTE_W-1:0] reg_addr;
        logic [BYTE_W-1:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              lcd_irq;
        logic [1:0]        mode;
        logic [LINE_W-1:0] line;
    } t_out_item;

    // Mode update from the timing unit to the status register
    typedef struct packed {
        logic  touch;
        t_mode mode;
    } t_mode_evt;

endpackage

// ===== sv/lcdt_timing.sv =====
module lcdt_timing (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_tick,
    output logic [lcdt_pkg::LINE_W-1:0] o_line_cur,
    output logic [lcdt_pkg::LINE_W-1:0] o_line_next,
    output lcdt_pkg::t_mode            o_mode_next,
    output lcdt_pkg::t_mode_evt        o_evt
);
    import lcdt_pkg::*;

    t_mode              r_mode, n_mode;
    logic [DOT_W-1:0]   r_dot,  n_dot;
    logic [LINE_W-1:0]  r_line, n_line;
    logic [DOT_W-1:0]   dot_inc;
    logic [LINE_W-1:0]  line_inc;
    logic               touch;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SEARCH;
            r_dot  <= '0;
            r_line <= '0;
        end else begin
            r_mode <= n_mode;
            r_dot  <= n_dot;
            r_line <= n_line;
        end
    end

    // Next state: dot counter, mode sequence, line counter
    always_comb begin
        dot_inc  = r_dot + DOT_W'(1);
        line_inc = r_line + LINE_W'(1);
        n_mode   = r_mode;
        n_dot    = r_dot;
        n_line   = r_line;
        touch    = 1'b0;
        if (i_tick) begin
            n_dot = dot_inc;
            touch = 1'b1;
            unique case (r_mode)
                MODE_SEARCH: begin
                    if (dot_inc >= SEARCH_END) n_mode = MODE_DRAW;
                    else touch = 1'b0;
                end
                MODE_DRAW: begin
                    if (dot_inc >= DRAW_END) n_mode = MODE_HBLANK;
                    else touch = 1'b0;
                end
                MODE_HBLANK: begin
                    if (dot_inc >= LINE_END) begin
                        n_line = line_inc;
                        n_mode = (line_inc >= VBLANK_START) ? MODE_VBLANK : MODE_SEARCH;
                        n_dot  = '0;
                    end else begin
                        touch = 1'b0;
                    end
                end
                MODE_VBLANK: begin
                    // every vblank tick refreshes the status mode bits
                    if (dot_inc >= LINE_END) begin
                        n_dot = '0;
                        if (line_inc >= FRAME_LINES) begin
                            n_line = '0;
                            n_mode = MODE_SEARCH;
                        end else begin
                            n_line = line_inc;
                        end
                    end
                end
            endcase
        end
    end

    assign o_line_cur  = r_line;
    assign o_line_next = n_line;
    assign o_mode_next = n_mode;
    assign o_evt.touch = touch;
    assign o_evt.mode  = n_mode;

endmodule

// ===== sv/lcdt_regfile.sv =====
module lcdt_regfile (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic                        i_wr_en,
    input  logic [lcdt_pkg::BYTE_W-1:0] i_addr,
    input  logic [lcdt_pkg::BYTE_W-1:0] i_wdata,
    input  logic [lcdt_pkg::LINE_W-1:0] i_line,
    input  lcdt_pkg::t_mode_evt         i_evt,
    output logic [lcdt_pkg::BYTE_W-1:0] o_rdata,
    output logic                        o_irq
);
    import lcdt_pkg::*;

    logic [BYTE_W-1:0] r_control, r_status, r_scroll_y, r_scroll_x, r_compare, r_dma;
    logic [BYTE_W-1:0] r_bg_pal, r_obj_pal0, r_obj_pal1, r_win_y, r_win_x;

    // Register writes; status low bits follow the timing unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control  <= CONTROL_RST;
            r_status   <= STATUS_RST;
            r_scroll_y <= '0;
            r_scroll_x <= '0;
            r_compare  <= '0;
            r_dma      <= '0;
            r_bg_pal   <= BG_PAL_RST;
            r_obj_pal0 <= OBJ_PAL_RST;
            r_obj_pal1 <= OBJ_PAL_RST;
            r_win_y    <= '0;
            r_win_x    <= '0;
        end else begin
            if (i_evt.touch) begin
                r_status <= (r_status & STATUS_KEEP) | BYTE_W'(i_evt.mode);
            end
            if (i_wr_en) begin
                unique case (i_addr)
                    ADDR_CONTROL:  r_control  <= i_wdata;
                    ADDR_STATUS:   r_status   <= (i_wdata & STATUS_KEEP) | STATUS_FORCED;
                    ADDR_SCROLL_Y: r_scroll_y <= i_wdata;
                    ADDR_SCROLL_X: r_scroll_x <= i_wdata;
                    ADDR_COMPARE:  r_compare  <= i_wdata;
                    ADDR_DMA:      r_dma      <= i_wdata;
                    ADDR_BG_PAL:   r_bg_pal   <= i_wdata;
                    ADDR_OBJ_PAL0: r_obj_pal0 <= i_wdata;
                    ADDR_OBJ_PAL1: r_obj_pal1 <= i_wdata;
                    ADDR_WIN_Y:    r_win_y    <= i_wdata;
                    ADDR_WIN_X:    r_win_x    <= i_wdata;
                    default: ;     // line register is read only, others unmapped
                endcase
            end
        end
    end

    // Read decode
    always_comb begin
        o_rdata = READ_IDLE_VALUE;
        if (i_rd_en) begin
            unique case (i_addr)
                ADDR_CONTROL:  o_rdata = r_control;
                ADDR_STATUS:   o_rdata = r_status;
                ADDR_SCROLL_Y: o_rdata = r_scroll_y;
                ADDR_SCROLL_X: o_rdata = r_scroll_x;
                ADDR_LINE:     o_rdata = i_line;
                ADDR_COMPARE:  o_rdata = r_compare;
                ADDR_DMA:      o_rdata = r_dma;
                ADDR_BG_PAL:   o_rdata = r_bg_pal;
                ADDR_OBJ_PAL0: o_rdata = r_obj_pal0;
                ADDR_OBJ_PAL1: o_rdata = r_obj_pal1;
                ADDR_WIN_Y:    o_rdata = r_win_y;
                ADDR_WIN_X:    o_rdata = r_win_x;
                default:       o_rdata = READ_IDLE_VALUE;
            endcase
        end
    end

    // Compare write against the current line
    assign o_irq = i_wr_en && (i_addr == ADDR_COMPARE) && (i_wdata == i_line);

endmodule

// ===== sv/lcd_line_timing_registers.sv =====
// LCD line timing and register block.
// Input channel (i_in_valid / o_in_stall / i_in_item): each item is a dot tick,
// a register read or a register write (addresses 0x40..0x4B).
// Output channel (o_out_valid / i_out_stall / o_out_item): exactly one result
// per item, in order: read data (0xFF unless a mapped read), compare interrupt,
// and the mode and line counter after the item.
// Stages: two register stages (input register, then result register); an
// item moves on to the result register when that register is empty or its
// result is taken. Throughput: one item per cycle while the receiver does not
// stall; the timing and register state update as the item's result is loaded.
// When the receiver stalls, the result register holds and the input register
// fills; o_in_stall rises only once both are occupied, and drops in the cycle
// the result is taken.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// block to line 0, sprite search, dot 0, with the register reset values.
module lcd_line_timing_registers (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lcdt_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lcdt_pkg::t_out_item o_out_item
);
    import lcdt_pkg::*;

    logic              r_in_valid;
    t_in_item          r_in_item;
    logic              r_out_valid;
    t_out_item         r_out_item;
    logic              advance, fire, accept;
    logic [LINE_W-1:0] line_cur, line_next;
    t_mode             mode_next;
    t_mode_evt         evt;
    logic [BYTE_W-1:0] rdata;
    logic              irq;

    // Handshake
    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_item <= i_in_item;
        end
    end

    lcdt_timing u_timing (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (fire && (r_in_item.op == OP_TICK)),
        .o_line_cur  (line_cur),
        .o_line_next (line_next),
        .o_mode_next (mode_next),
        .o_evt       (evt)
    );

    lcdt_regfile u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (r_in_item.op == OP_READ),
        .i_wr_en (fire && (r_in_item.op == OP_WRITE)),
        .i_addr  (r_in_item.reg_addr),
        .i_wdata (r_in_item.write_data),
        .i_line  (line_cur),
        .i_evt   (evt),
        .o_rdata (rdata),
        .o_irq   (irq)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_item.read_data <= rdata;
            r_out_item.lcd_irq   <= irq;
            r_out_item.mode      <= mode_next;
            r_out_item.line      <= line_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== sv/lcdt_checker.sv =====
module lcdt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input lcdt_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input lcdt_pkg::t_out_item o_out_item
);
    import lcdt_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // Line counter stays within the frame
    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.line < FRAME_LINES)
        else $error("line beyond frame");

    // Vertical blank exactly on the blank lines
    a_vblank_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_item.mode == MODE_VBLANK) == (o_out_item.line >= VBLANK_START)))
        else $error("mode and line disagree on vertical blank");

    // Interrupt only from a write, which reads back idle
    a_irq_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.lcd_irq |-> o_out_item.read_data == READ_IDLE_VALUE)
        else $error("interrupt on a read result");

endmodule

bind lcd_line_timing_registers lcdt_checker u_lcdt_checker (.*);
